// ===== src/tfn_pkg.sv =====
// tfn_pkg: shared widths, constants and sideband types of the face normal unit.
// Used by triangle_face_normal, tfn_isqrt, tfn_div3 and tfn_checker.
// Depends on nothing.
package tfn_pkg;

  // default coordinate width (signed Q4.12)
  localparam int COORD_BITS_DEF = 16;

  // scaled edge magnitudes stay below 2^EDGE_MAX_W
  localparam int EDGE_MAX_W = 31;

  // output format: signed Q2.14, three components in one word
  localparam int OUT_FRAC    = 14;
  localparam int OUT_W       = 16;
  localparam int OUT_TDATA_W = 3 * OUT_W;
  localparam int UNIT_ONE    = 1 << OUT_FRAC;

  // block scaling puts the largest cross magnitude in [2^29, 2^30)
  localparam int NORM_W = 30;
  // sum of three squares of NORM_W-bit values
  localparam int SUM_W  = 2 * NORM_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  // quotient never exceeds UNIT_ONE
  localparam int QUO_W  = OUT_FRAC + 1;
  // numerator m * 2^14 + r / 2
  localparam int NUM_W  = NORM_W + OUT_FRAC + 1;

  typedef logic [NORM_W-1:0] norm_t;
  typedef logic [QUO_W-1:0]  quo_t;

  // travels beside the square root
  typedef struct packed {
    norm_t [2:0] nm;
    logic  [2:0] neg;
    logic        degen;
  } sq_side_t;

  // travels beside the divider
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } div_side_t;

endpackage

// ===== src/tfn_isqrt.sv =====
// tfn_isqrt: pipelined integer square root, one result bit per stage.
// Carries a sq_side_t sideband with each word and stalls on en_i.
// Depends on tfn_pkg.
module tfn_isqrt
  import tfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  sq_side_t          side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sq_side_t          side_o
);

  localparam int NSTEP = SUM_W / 2;
  localparam int RW    = NSTEP + 2;

  logic [SUM_W-1:0]  rad_q  [NSTEP-1];
  logic [RW-1:0]     rem_q  [NSTEP-1];
  logic [ROOT_W-1:0] root_q [NSTEP];
  sq_side_t          sd_q   [NSTEP];
  logic              v_q    [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [SUM_W-1:0]  rad_in;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    sq_side_t          sd_in;
    logic              v_in;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     sub;
    logic [RW-1:0]     diff;
    logic              ge;

    // stage source: ports for the first step, previous step otherwise
    if (k == 0) begin : g_src
      assign rad_in  = sum_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sd_in   = side_i;
      assign v_in    = valid_i;
    end else begin : g_src
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sd_in   = sd_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // bring down the next two radicand bits, try 4*root + 1
    assign trial = {rem_in[RW-3:0], rad_in[SUM_W-1 -: 2]};
    assign sub   = {root_in, 2'b01};
    assign diff  = trial - sub;
    assign ge    = trial >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        sd_q[k]   <= sd_in;
      end
    end

    // partial remainder and radicand are not needed after the last step
    if (k < NSTEP - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff : trial;
          rad_q[k] <= {rad_in[SUM_W-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[NSTEP-1];
  assign root_o  = root_q[NSTEP-1];
  assign side_o  = sd_q[NSTEP-1];

endmodule

// ===== src/tfn_div3.sv =====
// tfn_div3: three pipelined restoring dividers sharing one divisor (the root).
// Forms the rounded numerators, then one quotient bit per stage; stalls on en_i.
// Depends on tfn_pkg.
module tfn_div3
  import tfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] root_i,
  input  sq_side_t          side_i,
  output logic              valid_o,
  output quo_t [2:0]        quo_o,
  output div_side_t         side_o
);

  localparam int NSTEP = QUO_W;

  // numerator stage: m * 2^14 + floor(r / 2), rounds half up
  logic [NUM_W-1:0]  num_d [3];
  logic [NUM_W-1:0]  num_q [3];
  logic [ROOT_W-1:0] den_q;
  div_side_t         sd0_q;
  logic              v0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = NUM_W'({side_i.nm[i], {OUT_FRAC{1'b0}}}) + NUM_W'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q     <= num_d;
      den_q     <= root_i;
      sd0_q.neg <= side_i.neg;
      sd0_q.degen <= side_i.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  // quotient steps, most significant bit first
  logic [NUM_W-1:0]  rem_q [NSTEP-1][3];
  logic [ROOT_W-1:0] dv_q  [NSTEP-1];
  quo_t              q_q   [NSTEP][3];
  div_side_t         sd_q  [NSTEP];
  logic              v_q   [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int B = NSTEP - 1 - k;

    logic [NUM_W-1:0]  rem_in [3];
    quo_t              q_in   [3];
    logic [ROOT_W-1:0] dv_in;
    div_side_t         sd_in;
    logic              v_in;
    logic [NUM_W:0]    dsh;
    logic [NUM_W:0]    diff   [3];
    logic              ge     [3];

    if (k == 0) begin : g_src
      assign rem_in = num_q;
      assign q_in   = '{default: '0};
      assign dv_in  = den_q;
      assign sd_in  = sd0_q;
      assign v_in   = v0_q;
    end else begin : g_src
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign v_in   = v_q[k-1];
    end

    // trial subtract of the shifted divisor; sign bit says it did not fit
    always_comb begin
      dsh = (NUM_W + 1)'(dv_in) << B;
      for (int i = 0; i < 3; i++) begin
        diff[i] = {1'b0, rem_in[i]} - dsh;
        ge[i]   = !diff[i][NUM_W];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          q_q[k][i] <= {q_in[i][QUO_W-2:0], ge[i]};
        end
        sd_q[k] <= sd_in;
      end
    end

    if (k < NSTEP - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int i = 0; i < 3; i++) begin
            rem_q[k][i] <= ge[i] ? diff[i][NUM_W-1:0] : rem_in[i];
          end
          dv_q[k] <= dv_in;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[NSTEP-1];
  assign side_o  = sd_q[NSTEP-1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_o[i] = q_q[NSTEP-1][i];
    end
  end

endmodule

// ===== src/triangle_face_normal.sv =====
// triangle_face_normal: unit face normal of one triangle per word, deep pipeline.
// Instantiates tfn_isqrt and tfn_div3; depends on tfn_pkg.
//
//   channel  dir  payload                                           handshake
//   s_axis   in   tdata: ax ay az bx by_coord bz cx cy cz (Q4.12)    tvalid/tready
//   m_axis   out  tdata: norm_x norm_y norm_z (Q2.14), tuser: degen  tvalid/tready
//
// One word enters per clock unless the pipe is frozen. From acceptance to tvalid a word
// passes 10 front stages (edges, cross product, block scaling, squares), 31 square root
// stages, 16 divider stages and the output register.
// Reset clears only the valid bits; no clearing pass.
// Backpressure freezes the whole pipe once the output register and its skid entry are
// both full; s_axis_tready_o comes from a flop, so m_axis_tready_i has no path to it.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_TDATA_W = ((9 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz (COORD_BITS each), zero pad on top
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // norm_x, norm_y, norm_z (OUT_W each)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                   m_axis_tuser_o
);

  localparam int CW   = COORD_BITS;
  localparam int EW   = CW + 1;                                 // edge width, signed
  localparam int EMW  = (EW > EDGE_MAX_W) ? EDGE_MAX_W : EW;    // scaled edge magnitude
  localparam int ESW  = EMW + 1;
  localparam int PW   = 2 * ESW;                                // products and cross terms
  localparam int NMW  = PW - 1;                                 // cross magnitude
  localparam int NG   = (NMW + 7) / 8;                          // byte groups for the search
  localparam int SHW  = (NMW > NORM_W) ? NMW : NORM_W;
  localparam int AMT_W = $clog2(SHW);
  localparam int FRONT = 10;

  logic en;
  logic [FRONT-1:0] v_q;

  // pipe advances unless the skid entry is occupied
  logic out_vld_q;
  logic skid_vld_q;
  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  // stage 1: edges B - A and C - A
  logic signed [EW-1:0] e1_d [6];
  logic signed [EW-1:0] e1_q [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i]   = EW'($signed(s_axis_tdata_i[(3 + i) * CW +: CW]))
                - EW'($signed(s_axis_tdata_i[i * CW +: CW]));
      e1_d[3+i] = EW'($signed(s_axis_tdata_i[(6 + i) * CW +: CW]))
                - EW'($signed(s_axis_tdata_i[i * CW +: CW]));
    end
  end

  // stage 2: wide edges shifted down by a common amount, truncating toward zero
  logic [EW-1:0]         m2    [6];
  logic [EMW-1:0]        ms2   [6];
  logic [EW-1:0]         e_or;
  logic [32:0]           e_or_w;
  logic [1:0]            sh2;
  logic signed [ESW-1:0] e2_d  [6];
  logic signed [ESW-1:0] e2_q  [6];

  always_comb begin
    e_or = '0;
    for (int i = 0; i < 6; i++) begin
      m2[i] = e1_q[i][EW-1] ? EW'(-e1_q[i]) : EW'(e1_q[i]);
      e_or  = e_or | m2[i];
    end
    e_or_w = 33'(e_or);
    priority if (e_or_w[32]) begin
      sh2 = 2'd2;
    end else if (e_or_w[31]) begin
      sh2 = 2'd1;
    end else begin
      sh2 = 2'd0;
    end
    for (int i = 0; i < 6; i++) begin
      ms2[i]  = EMW'(m2[i] >> sh2);
      e2_d[i] = e1_q[i][EW-1] ? -$signed({1'b0, ms2[i]}) : $signed({1'b0, ms2[i]});
    end
  end

  // stage 3: six products of the cross product
  logic signed [PW-1:0] p3_d [6];
  logic signed [PW-1:0] p3_q [6];

  always_comb begin
    p3_d[0] = e2_q[1] * e2_q[5];
    p3_d[1] = e2_q[2] * e2_q[4];
    p3_d[2] = e2_q[2] * e2_q[3];
    p3_d[3] = e2_q[0] * e2_q[5];
    p3_d[4] = e2_q[0] * e2_q[4];
    p3_d[5] = e2_q[1] * e2_q[3];
  end

  // stage 4: cross components
  logic signed [PW-1:0] n4_d [3];
  logic signed [PW-1:0] n4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n4_d[i] = p3_q[2*i] - p3_q[2*i+1];
    end
  end

  // stage 5: sign and magnitude
  logic [NMW-1:0] nm5_d [3];
  logic [NMW-1:0] nm5_q [3];
  logic [2:0]     neg5_d;
  logic [2:0]     neg5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg5_d[i] = n4_q[i][PW-1];
      nm5_d[i]  = neg5_d[i] ? NMW'(-n4_q[i]) : NMW'(n4_q[i]);
    end
  end

  // stage 6: leading one search, first pass per byte
  logic [NG*8-1:0]      or6;
  logic [NG-1:0]        gnz6_d;
  logic [NG-1:0]        gnz6_q;
  logic [NG-1:0][2:0]   gidx6_d;
  logic [NG-1:0][2:0]   gidx6_q;
  logic                 degen6_d;
  logic                 degen6_q;
  logic [NMW-1:0]       nm6_q [3];
  logic [2:0]           neg6_q;

  always_comb begin
    or6 = (NG * 8)'(nm5_q[0] | nm5_q[1] | nm5_q[2]);
    for (int g = 0; g < NG; g++) begin
      gnz6_d[g]  = |or6[g*8 +: 8];
      gidx6_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (or6[g*8 + j]) begin
          gidx6_d[g] = 3'(j);
        end
      end
    end
    degen6_d = ~|or6;
  end

  // stage 7: pick the top byte, turn the position into a shift toward bit 29
  logic               rsh7_d;
  logic               rsh7_q;
  logic [AMT_W-1:0]   amt7_d;
  logic [AMT_W-1:0]   amt7_q;
  logic [NMW-1:0]     nm7_q [3];
  logic [2:0]         neg7_q;
  logic               degen7_q;

  always_comb begin
    int pos;
    pos = 0;
    for (int g = 0; g < NG; g++) begin
      if (gnz6_q[g]) begin
        pos = g * 8 + int'(gidx6_q[g]);
      end
    end
    if (pos > NORM_W - 1) begin
      rsh7_d = 1'b1;
      amt7_d = AMT_W'(pos - (NORM_W - 1));
    end else begin
      rsh7_d = 1'b0;
      amt7_d = AMT_W'((NORM_W - 1) - pos);
    end
  end

  // stage 8: block scaling of all three magnitudes
  sq_side_t       side8_d;
  sq_side_t       side8_q;
  logic [SHW-1:0] ext8 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext8[i]        = SHW'(nm7_q[i]);
      side8_d.nm[i]  = rsh7_q ? NORM_W'(ext8[i] >> amt7_q) : NORM_W'(ext8[i] << amt7_q);
    end
    side8_d.neg   = neg7_q;
    side8_d.degen = degen7_q;
  end

  // stage 9: squares
  logic [2*NORM_W-1:0] sq9_d [3];
  logic [2*NORM_W-1:0] sq9_q [3];
  sq_side_t            side9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq9_d[i] = side8_q.nm[i] * side8_q.nm[i];
    end
  end

  // stage 10: sum of squares
  logic [SUM_W-1:0] sum10_d;
  logic [SUM_W-1:0] sum10_q;
  sq_side_t         side10_q;

  assign sum10_d = SUM_W'(sq9_q[0]) + SUM_W'(sq9_q[1]) + SUM_W'(sq9_q[2]);

  // front stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q     <= e1_d;
      e2_q     <= e2_d;
      p3_q     <= p3_d;
      n4_q     <= n4_d;
      nm5_q    <= nm5_d;
      neg5_q   <= neg5_d;
      nm6_q    <= nm5_q;
      neg6_q   <= neg5_q;
      gnz6_q   <= gnz6_d;
      gidx6_q  <= gidx6_d;
      degen6_q <= degen6_d;
      nm7_q    <= nm6_q;
      neg7_q   <= neg6_q;
      degen7_q <= degen6_q;
      rsh7_q   <= rsh7_d;
      amt7_q   <= amt7_d;
      side8_q  <= side8_d;
      sq9_q    <= sq9_d;
      side9_q  <= side8_q;
      sum10_q  <= sum10_d;
      side10_q <= side9_q;
    end
  end

  // front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FRONT-2:0], s_axis_tvalid_i};
    end
  end

  // square root of the sum
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  sq_side_t          side_s;

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[FRONT-1]),
    .sum_i   (sum10_q),
    .side_i  (side10_q),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (side_s)
  );

  // rounded quotients
  logic       vd;
  quo_t [2:0] quo_d;
  div_side_t  side_d;

  tfn_div3 u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .root_i  (root_s),
    .side_i  (side_s),
    .valid_o (vd),
    .quo_o   (quo_d),
    .side_o  (side_d)
  );

  // apply signs; a degenerate triangle gives a zero normal
  logic [OUT_TDATA_W-1:0] res_d;
  logic [OUT_W-1:0]       mag_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = OUT_W'(quo_d[i]);
      if (side_d.degen) begin
        res_d[i*OUT_W +: OUT_W] = '0;
      end else if (side_d.neg[i]) begin
        res_d[i*OUT_W +: OUT_W] = -mag_d[i];
      end else begin
        res_d[i*OUT_W +: OUT_W] = mag_d[i];
      end
    end
  end

  // output register and skid entry
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_user_q;
  logic [OUT_TDATA_W-1:0] skid_data_q;
  logic                   skid_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        // pipe frozen; the skid word moves up when the output is taken
        if (m_axis_tready_i) begin
          skid_vld_q <= 1'b0;
        end
      end else if (vd) begin
        if (out_vld_q && !m_axis_tready_i) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (vd) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_data_q <= res_d;
        skid_user_q <= side_d.degen;
      end else begin
        out_data_q <= res_d;
        out_user_q <= side_d.degen;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== src/tfn_checker.sv =====
// tfn_checker: port-level checks on the result stream of triangle_face_normal.
// Bound to the top level below; depends on tfn_pkg.
module tfn_checker
  import tfn_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input logic                   m_axis_tuser_i
);

  logic signed [OUT_W-1:0] nx;
  logic signed [OUT_W-1:0] ny;
  logic signed [OUT_W-1:0] nz;

  assign nx = m_axis_tdata_i[0 +: OUT_W];
  assign ny = m_axis_tdata_i[OUT_W +: OUT_W];
  assign nz = m_axis_tdata_i[2*OUT_W +: OUT_W];

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result word dropped while stalled");

  // a stalled word does not change
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result word changed while stalled");

  // degenerate triangle carries a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i == '0)
    else $error("degenerate word with nonzero normal");

  // a unit normal is never zero and stays within plus or minus one
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i |->
      m_axis_tdata_i != '0 &&
      nx <= UNIT_ONE && nx >= -UNIT_ONE &&
      ny <= UNIT_ONE && ny >= -UNIT_ONE &&
      nz <= UNIT_ONE && nz >= -UNIT_ONE)
    else $error("normal component out of range or zero");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// ===== tb/sv/tb_triangle_face_normal.sv =====
// tb_triangle_face_normal: self-checking bench for the triangle face normal unit.
// Drives triangles with random gaps and stalls, predicts each unit normal in place.
// Depends on tfn_pkg and triangle_face_normal.
`timescale 1ns / 1ps

module tb_triangle_face_normal;
  import tfn_pkg::*;

  localparam int COORD_W   = COORD_BITS_DEF;
  localparam int IN_W      = ((9 * COORD_W + 7) / 8) * 8;
  localparam int RAND_TRIS = 2000;
  localparam int DRAIN_CYC = 80;
  localparam int MAX_WAIT  = 17;
  localparam longint CYCLE_LIMIT = 600000;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one expected output word
  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             degen;
  } normal_t;

  // Expected unit normals, oldest first, and the check against the output port
  class normal_scoreboard;
    normal_t     expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // digit-by-digit floor square root
    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v    -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // edges from A, cross product, block scaling to [2^29, 2^30), rounded divide
    function normal_t face_normal(logic [IN_W-1:0] word);
      coord_t          c;
      longint          vtx[9];
      longint          e[6];
      longint          n[3];
      longint unsigned nm[3];
      longint unsigned mx, sq_sum, root, q;
      logic [OUT_W-1:0] comp[3];
      int              rs, ls;
      normal_t         res;
      for (int i = 0; i < 9; i++) begin
        c      = word[i*COORD_W +: COORD_W];
        vtx[i] = c;
      end
      // edges are 17 bits here, so no pre-shift of wide edges is needed
      for (int i = 0; i < 3; i++) begin
        e[i]     = vtx[3+i] - vtx[i];
        e[3+i]   = vtx[6+i] - vtx[i];
      end
      n[0] = e[1] * e[5] - e[2] * e[4];
      n[1] = e[2] * e[3] - e[0] * e[5];
      n[2] = e[0] * e[4] - e[1] * e[3];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        nm[i] = (n[i] < 0) ? -n[i] : n[i];
        if (nm[i] > mx) mx = nm[i];
      end
      res = '0;
      if (mx == 0) begin
        res.degen = 1'b1;
        return res;
      end
      rs = 0;
      while ((mx >> rs) >= (64'd1 << 30)) rs++;
      mx >>= rs;
      ls = 0;
      while ((mx << ls) < (64'd1 << 29)) ls++;
      sq_sum = 0;
      for (int i = 0; i < 3; i++) begin
        nm[i]   = (nm[i] >> rs) << ls;
        sq_sum += nm[i] * nm[i];
      end
      root = floor_sqrt(sq_sum);
      // magnitude rounded half up, sign applied afterwards
      for (int i = 0; i < 3; i++) begin
        q       = ((nm[i] << OUT_FRAC) + (root >> 1)) / root;
        comp[i] = q[OUT_W-1:0];
        if (n[i] < 0) comp[i] = -comp[i];
      end
      res.nx = comp[0];
      res.ny = comp[1];
      res.nz = comp[2];
      return res;
    endfunction

    function void note_triangle(logic [IN_W-1:0] word);
      expected_q.insert(expected_q.size(), face_normal(word));
    endfunction

    function void check_normal(logic [OUT_TDATA_W-1:0] data, logic degen);
      normal_t exp_n;
      if (expected_q.size() == 0) begin
        $error("output word with no triangle pending: tdata %h tuser %b", data, degen);
        mismatches++;
        return;
      end
      exp_n = expected_q.pop_front();
      if (data[OUT_W-1:0] !== exp_n.nx) begin
        $error("norm_x: expected %0d, got %0d", $signed(exp_n.nx), $signed(data[OUT_W-1:0]));
        mismatches++;
      end
      if (data[2*OUT_W-1:OUT_W] !== exp_n.ny) begin
        $error("norm_y: expected %0d, got %0d", $signed(exp_n.ny),
               $signed(data[2*OUT_W-1:OUT_W]));
        mismatches++;
      end
      if (data[3*OUT_W-1:2*OUT_W] !== exp_n.nz) begin
        $error("norm_z: expected %0d, got %0d", $signed(exp_n.nz),
               $signed(data[3*OUT_W-1:2*OUT_W]));
        mismatches++;
      end
      if (degen !== exp_n.degen) begin
        $error("degenerate: expected %0d, got %0d", exp_n.degen, degen);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_n;
  logic                   s_valid;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_data;
  logic                   m_axis_tvalid_o;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  normal_scoreboard sb = new();
  int unsigned words_in    = 0;
  int unsigned results_out = 0;
  longint      cycle_cnt   = 0;

  triangle_face_normal dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // cycle count and hard stop
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // handshake monitor on both channels
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_valid && s_axis_tready_o) begin
        sb.note_triangle(s_data);
        words_in++;
      end
      if (m_axis_tvalid_o && m_ready) begin
        sb.check_normal(m_axis_tdata_o, m_axis_tuser_o);
        results_out++;
      end
    end
  end

  // wait before each input word and each output take; every third stretch runs without gaps
  function automatic int draw_wait();
    if (((cycle_cnt / 2500) % 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [IN_W-1:0] pack_triangle(input int v[9]);
    logic [IN_W-1:0] word;
    word = '0;
    for (int i = 0; i < 9; i++) word[i*COORD_W +: COORD_W] = v[i][COORD_W-1:0];
    return word;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_triangle(input int v[9]);
    int          gap;
    int unsigned seen;
    gap = draw_wait();
    repeat (gap) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= pack_triangle(v);
    seen = words_in;
    do @(negedge clk_i); while (words_in == seen);
  endtask

  task automatic send_vertices(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    int v[9];
    v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    send_triangle(v);
  endtask

  // random triangle: full range, small, collinear or nearly collinear
  task automatic send_random_triangle();
    int v[9];
    int lim, k, kind;
    kind = $urandom_range(0, 9);
    lim  = 1 << $urandom_range(0, 12);
    for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < 3; i++) begin
      if (kind <= 3) begin
        v[3+i] = int'($urandom_range(0, 65535)) - 32768;
        v[6+i] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        v[3+i] = v[i] + int'($urandom_range(0, 2 * lim)) - lim;
        v[6+i] = v[i] + int'($urandom_range(0, 2 * lim)) - lim;
      end
    end
    if (kind == 7 || kind == 8) begin
      // collinear or coincident vertices
      k = int'($urandom_range(0, 4)) - 2;
      for (int i = 0; i < 3; i++) v[6+i] = v[i] + k * (v[3+i] - v[i]);
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 3; i++) v[3+i] = v[i];
    end else if (kind == 9) begin
      // nearly collinear: one small nudge off the line
      for (int i = 0; i < 3; i++) v[6+i] = v[i] + 2 * (v[3+i] - v[i]);
      v[6 + $urandom_range(0, 2)] += int'($urandom_range(0, 2)) - 1;
    end
    send_triangle(v);
  endtask

  // output side: random stall before taking each word
  initial begin
    int          stall;
    int unsigned seen;
    m_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk_i);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        m_ready <= 1'b0;
        @(negedge clk_i);
      end
      m_ready <= 1'b1;
      seen = results_out;
      do @(negedge clk_i); while (results_out == seen);
    end
  end

  // reset, directed triangles, random triangles, drain
  initial begin
    rst_n   = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // degenerate: all zero, coincident, collinear, collinear across full range
    send_vertices(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vertices(100, -200, 300, 100, -200, 300, 100, -200, 300);
    send_vertices(0, 0, 0, 1, 2, 3, 2, 4, 6);
    send_vertices(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767);
    // axis-aligned normals, both windings, unit and tiny edges
    send_vertices(0, 0, 0, 4096, 0, 0, 0, 0, 4096);
    send_vertices(0, 0, 0, 0, 0, 4096, 4096, 0, 0);
    send_vertices(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_vertices(0, 0, 0, 0, 1, 0, 0, 0, 1);
    send_vertices(-1, -1, -1, 0, -1, -1, -1, 0, -1);
    send_vertices(0, 0, 0, 0, 0, 1, 0, 1, 1);
    // oblique normals
    send_vertices(0, 0, 0, 1, -1, 0, 0, 1, -1);
    send_vertices(1, 2, 3, -32768, 32767, 5, 7, -32768, 32767);
    // largest edges, cross product needs scaling down
    send_vertices(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
    send_vertices(32767, 32767, 32767, -32768, 32767, -32768, -32768, -32768, 32767);
    send_vertices(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768);
    // nearly collinear at full scale
    send_vertices(-32768, -32768, -32768, 32767, 32767, 32766, 32767, 32766, 32767);

    repeat (RAND_TRIS) send_random_triangle();
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tfn_pkg.sv
src/tfn_isqrt.sv
src/tfn_div3.sv
src/triangle_face_normal.sv
src/tfn_checker.sv
tb/sv/tb_triangle_face_normal.sv
